### src/nfpfa_pkg.sv
// Shared constants and types for the next-fit page frame allocator.
package nfpfa_pkg;

  // Register width of page_count, first_free_frame and the search pointer.
  localparam int REG_W        = 17;
  localparam int PAGE_SHIFT   = 12;
  localparam int IN_ADDR_W    = 32;
  localparam int OUT_ADDR_W   = 28;
  localparam int IDX_W        = IN_ADDR_W - PAGE_SHIFT;

  // Used bitmap is held as words of WORD_W frames.
  localparam int WORD_SHIFT   = 6;
  localparam int WORD_W       = 1 << WORD_SHIFT;
  localparam int ROW_W        = REG_W - WORD_SHIFT;

  localparam int MAX_FRAMES_DEF = 65536;

  // Configuration port.
  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_PAGE_COUNT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_FREE = 8'd1;

  localparam logic [REG_W-1:0] PAGE_COUNT_RST = 17'd65536;
  localparam logic [REG_W-1:0] FIRST_FREE_RST = 17'd1024;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_FRAME = 2'd1,
    ST_RANGE    = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

endpackage

### src/nfpfa_bitmap.sv
// Used-frame bitmap: one write port, one read port, registered read data.
module nfpfa_bitmap #(
  parameter int  DEPTH = 1024,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                          clk_i,
  input  logic                          wr_en_i,
  input  logic [AW-1:0]                 wr_addr_i,
  input  logic [nfpfa_pkg::WORD_W-1:0]  wr_data_i,
  input  logic                          rd_en_i,
  input  logic [AW-1:0]                 rd_addr_i,
  output logic [nfpfa_pkg::WORD_W-1:0]  rd_data_o
);

  logic [nfpfa_pkg::WORD_W-1:0] mem_q [DEPTH];
  logic [nfpfa_pkg::WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### src/next_fit_page_frame_allocator.sv
// Next-fit page frame allocator: used bitmap in memory, word-wide scan.
//
//  channel  | signals                                   | direction | handshake
//  ---------+-------------------------------------------+-----------+---------------------
//  request  | start_i req_type_i free_address_i         | in        | start_i && !busy_o
//  result   | done_o frame_address_o status_o           | out       | done_o, one cycle
//  config   | cfg_valid_i cfg_index_i cfg_data_i        | in        | cfg_valid_i && cfg_ready_o
//
// A free answers in the cycle after acceptance when out of range, otherwise via S_FREE.
// An allocate reads one bitmap word of 64 frames per cycle through the single read
// port while words of the current range remain, checks each word after its read and
// wraps once to the first allocatable frame; ROWS is MAX_FRAMES/64 rounded up. The next
// item is taken once busy_o drops.
// Reset: a clearing pass writes every bitmap row to zero with busy_o high; configuration
// writes are taken throughout. The receiver cannot stall: every result is shown for
// exactly one cycle on done_o.
module next_fit_page_frame_allocator #(
  parameter int MAX_FRAMES = nfpfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic                               req_type_i,
  input  logic [nfpfa_pkg::IN_ADDR_W-1:0]    free_address_i,
  // result
  output logic                               done_o,
  output logic [nfpfa_pkg::OUT_ADDR_W-1:0]   frame_address_o,
  output logic [1:0]                         status_o,
  // configuration
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [nfpfa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [nfpfa_pkg::REG_W-1:0]        cfg_data_i
);

  localparam int ROWS  = (MAX_FRAMES + nfpfa_pkg::WORD_W - 1) / nfpfa_pkg::WORD_W;
  localparam int RAW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int RW    = nfpfa_pkg::REG_W;
  localparam int BW    = nfpfa_pkg::WORD_SHIFT;
  localparam int WW    = nfpfa_pkg::WORD_W;
  localparam int ROW_W = nfpfa_pkg::ROW_W;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_SCAN  = 3'd2;
  localparam logic [2:0] S_FREE  = 3'd3;

  logic [2:0]       state_q, state_d;
  logic [RAW-1:0]   clr_q, clr_d;
  logic [RW-1:0]    page_count_q, first_q, search_q, search_d;
  logic             phase_q, phase_d;
  logic [RW-1:0]    lo_q, lo_d, hlast_q, hlast_d, wrap_hi_q, wrap_hi_d;
  logic [ROW_W-1:0] rd_row_q, rd_row_d, pend_row_q, pend_row_d;
  logic             more_q, more_d, pend_q, pend_d;
  logic [RW-1:0]    free_idx_q, free_idx_d;
  logic             done_q, done_d;
  logic [nfpfa_pkg::OUT_ADDR_W-1:0] addr_q, addr_d;
  logic [1:0]       status_q, status_d;

  // Memory port signals
  logic             wr_en, rd_en;
  logic [RAW-1:0]   wr_addr, rd_addr;
  logic [WW-1:0]    wr_data, rd_data;

  // Request decode
  logic                        accept;
  logic [RW-1:0]               limit, start_fr, wrap_hi;
  logic [nfpfa_pkg::IDX_W-1:0] idx_in;
  logic                        idx_bad;

  // Word scan
  logic [WW-1:0] cand;
  logic          hit;
  logic [BW-1:0] hit_bit;
  logic [RW-1:0] found;

  assign accept      = start_i && (state_q == S_IDLE);
  assign busy_o      = (state_q != S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Frame limit is the smaller of page_count and the bitmap size.
  assign limit    = (32'(page_count_q) < 32'(MAX_FRAMES)) ? page_count_q : RW'(MAX_FRAMES);
  assign start_fr = (search_q < first_q) ? first_q : search_q;
  assign wrap_hi  = (start_fr < limit) ? start_fr : limit;
  assign idx_in   = free_address_i[nfpfa_pkg::IN_ADDR_W-1:nfpfa_pkg::PAGE_SHIFT];
  assign idx_bad  = (idx_in < nfpfa_pkg::IDX_W'(first_q)) ||
                    (idx_in >= nfpfa_pkg::IDX_W'(limit));

  // Free frames of the pending word that lie inside the current scan window.
  always_comb begin
    for (int b = 0; b < WW; b++) begin
      cand[b] = !rd_data[b]
             && (pend_row_q != lo_q[RW-1:BW] || BW'(b) >= lo_q[BW-1:0])
             && (pend_row_q != hlast_q[RW-1:BW] || BW'(b) <= hlast_q[BW-1:0]);
    end
    hit_bit = '0;
    for (int b = WW - 1; b >= 0; b--) begin
      if (cand[b]) begin
        hit_bit = BW'(b);
      end
    end
  end

  assign hit   = pend_q && (|cand);
  assign found = {pend_row_q, hit_bit};

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    search_d   = search_q;
    phase_d    = phase_q;
    lo_d       = lo_q;
    hlast_d    = hlast_q;
    wrap_hi_d  = wrap_hi_q;
    rd_row_d   = rd_row_q;
    pend_row_d = pend_row_q;
    more_d     = more_q;
    pend_d     = 1'b0;
    free_idx_d = free_idx_q;
    done_d     = 1'b0;
    addr_d     = addr_q;
    status_d   = status_q;
    wr_en      = 1'b0;
    wr_addr    = RAW'(pend_row_q);
    wr_data    = rd_data;
    rd_en      = 1'b0;
    rd_addr    = RAW'(rd_row_q);

    case (state_q)
      S_CLEAR: begin
        // Sweep one row a cycle.
        wr_en   = 1'b1;
        wr_addr = clr_q;
        wr_data = '0;
        clr_d   = clr_q + RAW'(1);
        if (clr_q == RAW'(ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (accept) begin
          if (req_type_i == nfpfa_pkg::REQ_ALLOC) begin
            // Raise the pointer to the first allocatable frame, set up the upper scan.
            search_d  = start_fr;
            phase_d   = 1'b0;
            lo_d      = start_fr;
            hlast_d   = limit - RW'(1);
            wrap_hi_d = wrap_hi;
            rd_row_d  = start_fr[RW-1:BW];
            more_d    = (start_fr < limit);
            state_d   = S_SCAN;
          end else if (idx_bad) begin
            done_d   = 1'b1;
            addr_d   = '0;
            status_d = nfpfa_pkg::ST_RANGE;
          end else begin
            free_idx_d = RW'(idx_in);
            rd_en      = 1'b1;
            rd_addr    = RAW'(idx_in[RW-1:BW]);
            state_d    = S_FREE;
          end
        end
      end

      S_SCAN: begin
        if (hit) begin
          // Mark the frame, move the pointer past it, answer.
          wr_en    = 1'b1;
          wr_data  = rd_data | (WW'(1) << hit_bit);
          search_d = found + RW'(1);
          done_d   = 1'b1;
          addr_d   = {found[nfpfa_pkg::OUT_ADDR_W-nfpfa_pkg::PAGE_SHIFT-1:0],
                      nfpfa_pkg::PAGE_SHIFT'(0)};
          status_d = nfpfa_pkg::ST_OK;
          state_d  = S_IDLE;
        end else if (more_q) begin
          // Issue the next word while the previous one is checked.
          rd_en      = 1'b1;
          pend_d     = 1'b1;
          pend_row_d = rd_row_q;
          if (rd_row_q == hlast_q[RW-1:BW]) begin
            more_d = 1'b0;
          end else begin
            rd_row_d = rd_row_q + ROW_W'(1);
          end
        end else if (!phase_q) begin
          // Upper range exhausted: wrap to the first allocatable frame.
          phase_d  = 1'b1;
          lo_d     = first_q;
          hlast_d  = wrap_hi_q - RW'(1);
          rd_row_d = first_q[RW-1:BW];
          more_d   = (first_q < wrap_hi_q);
        end else begin
          done_d   = 1'b1;
          addr_d   = '0;
          status_d = nfpfa_pkg::ST_NO_FRAME;
          state_d  = S_IDLE;
        end
      end

      S_FREE: begin
        done_d  = 1'b1;
        addr_d  = '0;
        wr_addr = RAW'(free_idx_q[RW-1:BW]);
        if (!rd_data[free_idx_q[BW-1:0]]) begin
          status_d = nfpfa_pkg::ST_NOT_USED;
        end else begin
          wr_en    = 1'b1;
          wr_data  = rd_data & ~(WW'(1) << free_idx_q[BW-1:0]);
          status_d = nfpfa_pkg::ST_OK;
        end
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      clr_q        <= '0;
      search_q     <= '0;
      more_q       <= 1'b0;
      pend_q       <= 1'b0;
      phase_q      <= 1'b0;
      done_q       <= 1'b0;
      page_count_q <= nfpfa_pkg::PAGE_COUNT_RST;
      first_q      <= nfpfa_pkg::FIRST_FREE_RST;
    end else begin
      state_q  <= state_d;
      clr_q    <= clr_d;
      search_q <= search_d;
      more_q   <= more_d;
      pend_q   <= pend_d;
      phase_q  <= phase_d;
      done_q   <= done_d;
      if (cfg_valid_i) begin
        case (cfg_index_i)
          nfpfa_pkg::CFG_PAGE_COUNT: page_count_q <= cfg_data_i;
          nfpfa_pkg::CFG_FIRST_FREE: first_q      <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Payload: no reset needed.
  always_ff @(posedge clk_i) begin
    lo_q       <= lo_d;
    hlast_q    <= hlast_d;
    wrap_hi_q  <= wrap_hi_d;
    rd_row_q   <= rd_row_d;
    pend_row_q <= pend_row_d;
    free_idx_q <= free_idx_d;
    addr_q     <= addr_d;
    status_q   <= status_d;
  end

  nfpfa_bitmap #(
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign done_o          = done_q;
  assign frame_address_o = addr_q;
  assign status_o        = status_q;

  // A failed or free answer never carries an address.
  a_fail_no_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != nfpfa_pkg::ST_OK) |-> (frame_address_o == '0))
    else $error("failure result carries an address");

  // Bitmap writes happen only while busy, never alongside an accepted item.
  a_no_wr_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !wr_en)
    else $error("bitmap write coincides with an accepted item");

  // A pending word is only checked inside a scan.
  a_pend_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == S_SCAN))
    else $error("pending bitmap word outside a scan");

  // No result during the clearing pass.
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLEAR) |-> !done_o)
    else $error("result during clearing pass");

endmodule
